// ----- rtl/dopp_pkg.sv -----
// DHCPv6 option parser package: item structs, verdict codes and frame layout constants.
// Used by the parser top level and by its port checker.
`default_nettype none

package dopp_pkg;

  localparam int DEFAULT_MAX_FRAME_BYTES = 65536;
  localparam int MAX_OPTIONS_W           = 10;
  localparam logic [MAX_OPTIONS_W-1:0] MAX_OPTIONS_RESET = 10'd512;

  localparam logic [7:0] ETH_TYPE_HI = 8'h86;
  localparam logic [7:0] ETH_TYPE_LO = 8'hDD;
  localparam logic [7:0] NH_UDP      = 8'd17;

  localparam int POS_ETH_HI   = 12;
  localparam int POS_ETH_LO   = 13;
  localparam int ETH_HDR_LEN  = 14;
  localparam int POS_NEXT_HDR = 20;
  localparam int UDP_HDR_END  = 54;
  localparam int POS_MSG_TYPE = 62;
  localparam int POS_XID_LO   = 63;
  localparam int POS_XID_HI   = 65;
  localparam int OPT_START    = 66;

  localparam int FIFO_DEPTH   = 4;

  typedef enum logic [2:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_NOT_IPV6   = 3'd1,
    VERDICT_NOT_UDP    = 3'd2,
    VERDICT_TRUNCATED  = 3'd3,
    VERDICT_MALFORMED  = 3'd4,
    VERDICT_DUP_CLIENT = 3'd5,
    VERDICT_DUP_SERVER = 3'd6
  } verdict_t;

  typedef enum logic {
    KIND_OPTION  = 1'b0,
    KIND_VERDICT = 1'b1
  } record_kind_t;

  localparam logic [15:0] OPT_CLIENT_ID = 16'd1;
  localparam logic [15:0] OPT_SERVER_ID = 16'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    record_kind_t              record_kind;
    logic [15:0]               tlv_code;
    logic [15:0]               option_length;
    logic [15:0]               data_offset;
    verdict_t                  verdict;
    logic [7:0]                message_type;
    logic [23:0]               transaction_id;
    logic [MAX_OPTIONS_W-1:0]  options_found;
    logic                      end_of_run;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/dhcpv6_packet_option_parser.sv -----
// DHCPv6 option parser top level: header checks, option TLV split and verdict per frame.
// Depends on dopp_pkg.
//
//   channel | ports                               | payload
//   in      | in_valid / in_ready / in_data       | in_item_t, one frame byte
//   out     | out_valid / out_ready / out_data    | out_item_t, option or verdict
//   cfg     | cfg_we / cfg_wdata                  | max_options, no wait
//
// One byte per cycle: a byte enters the input register, then the parse logic updates
// the frame state and pushes up to two items into a four-entry result queue.
// A byte is parsed while the queue has room for two items; the queue drains one item
// per cycle while out_ready is high; a stalled out side stops in_ready at three items.
// Synchronous active-low reset clears frame state, queue and sets max_options to 512.
`default_nettype none

module dhcpv6_packet_option_parser
  import dopp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_item_t                     out_data,
  input  wire logic                     cfg_we,
  input  wire logic [MAX_OPTIONS_W-1:0] cfg_wdata
);

  localparam int PW  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int QAW = $clog2(FIFO_DEPTH);
  localparam int QCW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_OH0  = 3'd1,
    PH_OH1  = 3'd2,
    PH_OH2  = 3'd3,
    PH_OH3  = 3'd4,
    PH_DATA = 3'd5,
    PH_STOP = 3'd6
  } phase_t;

  logic [MAX_OPTIONS_W-1:0] max_opt_r;

  logic     ir_valid_r;
  in_item_t ir_data_r;

  logic [PW-1:0]            pos_r,  pos_nxt;
  logic [7:0]               eth_hi_r, eth_hi_nxt;
  logic [1:0]               hc_r,   hc_nxt;
  logic [7:0]               mtype_r, mtype_nxt;
  logic [23:0]              xid_r,  xid_nxt;
  logic [31:0]              hsh_r,  hsh_nxt;
  phase_t                   ph_r,   ph_nxt;
  logic [15:0]              left_r, left_nxt;
  logic [MAX_OPTIONS_W-1:0] cnt_r,  cnt_nxt;
  logic [1:0]               ids_r,  ids_nxt;
  verdict_t                 rv_r,   rv_nxt;

  out_item_t             q_mem_r [FIFO_DEPTH];
  logic [QAW-1:0]        q_wp_r, q_rp_r;
  logic [QCW-1:0]        q_cnt_r;

  logic        proc;
  logic        opt_emit;
  logic [15:0] opt_code, opt_len, opt_off;
  verdict_t    fin_verdict;
  out_item_t   opt_rec, ver_rec, rec0, rec1;
  logic [1:0]  push_n;
  logic        pop;
  logic [7:0]  b;

  assign proc     = ir_valid_r && (q_cnt_r <= QCW'(FIFO_DEPTH - 2));
  assign in_ready = !ir_valid_r || proc;
  assign b        = ir_data_r.frame_byte;

  always_comb begin
    logic [MAX_OPTIONS_W-1:0] cnt_acc;
    pos_nxt    = pos_r;
    eth_hi_nxt = eth_hi_r;
    hc_nxt     = hc_r;
    mtype_nxt  = mtype_r;
    xid_nxt    = xid_r;
    hsh_nxt    = hsh_r;
    ph_nxt     = ph_r;
    left_nxt   = left_r;
    cnt_nxt    = cnt_r;
    ids_nxt    = ids_r;
    rv_nxt     = rv_r;
    opt_emit   = 1'b0;
    opt_code   = hsh_r[31:16];
    opt_len    = hsh_r[15:0];
    opt_off    = '0;
    cnt_acc    = cnt_r + MAX_OPTIONS_W'(1);

    if (pos_r < PW'(MAX_FRAME_BYTES)) begin
      pos_nxt = pos_r + PW'(1);
      if (pos_r == PW'(POS_ETH_HI)) begin
        eth_hi_nxt = b;
      end else if (pos_r == PW'(POS_ETH_LO)) begin
        if (eth_hi_r != ETH_TYPE_HI || b != ETH_TYPE_LO) hc_nxt[0] = 1'b1;
      end else if (pos_r == PW'(POS_NEXT_HDR)) begin
        if (b != NH_UDP) hc_nxt[1] = 1'b1;
      end else if (pos_r == PW'(POS_MSG_TYPE)) begin
        mtype_nxt = b;
      end else if (pos_r >= PW'(POS_XID_LO) && pos_r <= PW'(POS_XID_HI)) begin
        xid_nxt = {xid_r[15:0], b};
        if (pos_r == PW'(POS_XID_HI)) ph_nxt = (cnt_r < max_opt_r) ? PH_OH0 : PH_STOP;
      end else if (pos_r >= PW'(OPT_START) && hc_r == 2'b00) begin
        case (ph_r)
          PH_OH0, PH_OH1, PH_OH2, PH_OH3: begin
            hsh_nxt = {hsh_r[23:0], b};
            ph_nxt  = phase_t'(ph_r + 3'd1);
            if (ph_r == PH_OH3) begin
              opt_code = hsh_nxt[31:16];
              opt_len  = hsh_nxt[15:0];
              left_nxt = hsh_nxt[15:0];
              if (hsh_nxt[15:0] == 16'd0) begin
                opt_emit = 1'b1;
                opt_off  = 16'(pos_r) + 16'd1;
              end
            end
          end
          PH_DATA: begin
            left_nxt = left_r - 16'd1;
            if (left_r == 16'd1) begin
              opt_emit = 1'b1;
              opt_off  = 16'(pos_r) - hsh_r[15:0] + 16'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (opt_emit) begin
      cnt_nxt = cnt_acc;
      if (opt_code == OPT_CLIENT_ID) begin
        if (ids_r[0] && rv_r == VERDICT_OK) rv_nxt = VERDICT_DUP_CLIENT;
        ids_nxt[0] = 1'b1;
      end else if (opt_code == OPT_SERVER_ID) begin
        if (ids_r[1] && rv_r == VERDICT_OK) rv_nxt = VERDICT_DUP_SERVER;
        ids_nxt[1] = 1'b1;
      end
      ph_nxt = (cnt_acc < max_opt_r) ? PH_OH0 : PH_STOP;
    end

    if (pos_nxt < PW'(ETH_HDR_LEN) || hc_nxt[0]) begin
      fin_verdict = VERDICT_NOT_IPV6;
    end else if (pos_nxt < PW'(UDP_HDR_END)) begin
      fin_verdict = VERDICT_TRUNCATED;
    end else if (hc_nxt[1]) begin
      fin_verdict = VERDICT_NOT_UDP;
    end else if (pos_nxt < PW'(OPT_START)) begin
      fin_verdict = VERDICT_TRUNCATED;
    end else if (ph_nxt inside {PH_OH1, PH_OH2, PH_OH3, PH_DATA}) begin
      fin_verdict = VERDICT_MALFORMED;
    end else begin
      fin_verdict = rv_nxt;
    end
  end

  always_comb begin
    opt_rec                = '0;
    opt_rec.record_kind    = KIND_OPTION;
    opt_rec.tlv_code       = opt_code;
    opt_rec.option_length  = opt_len;
    opt_rec.data_offset    = opt_off;
    opt_rec.verdict        = VERDICT_OK;
    opt_rec.message_type   = mtype_nxt;
    opt_rec.transaction_id = xid_nxt;
    opt_rec.options_found  = cnt_nxt;
    opt_rec.end_of_run     = !ir_data_r.is_last;

    ver_rec                = '0;
    ver_rec.record_kind    = KIND_VERDICT;
    ver_rec.verdict        = fin_verdict;
    ver_rec.message_type   = mtype_nxt;
    ver_rec.transaction_id = xid_nxt;
    ver_rec.options_found  = cnt_nxt;
    ver_rec.end_of_run     = 1'b1;

    rec0   = opt_emit ? opt_rec : ver_rec;
    rec1   = ver_rec;
    push_n = 2'd0;
    if (proc) push_n = 2'(opt_emit) + 2'(ir_data_r.is_last);
  end

  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_mem_r[q_rp_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_mem_r[q_wp_r] <= rec0;
    if (push_n == 2'd2) q_mem_r[q_wp_r + QAW'(1)] <= rec1;
    if (in_valid && in_ready) ir_data_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_opt_r  <= MAX_OPTIONS_RESET;
      ir_valid_r <= 1'b0;
      q_wp_r     <= '0;
      q_rp_r     <= '0;
      q_cnt_r    <= '0;
      pos_r      <= '0;
      eth_hi_r   <= '0;
      hc_r       <= '0;
      mtype_r    <= '0;
      xid_r      <= '0;
      hsh_r      <= '0;
      ph_r       <= PH_HDR;
      left_r     <= '0;
      cnt_r      <= '0;
      ids_r      <= '0;
      rv_r       <= VERDICT_OK;
    end else begin
      if (cfg_we) max_opt_r <= cfg_wdata;
      if (in_ready) ir_valid_r <= in_valid;
      q_wp_r  <= q_wp_r + QAW'(push_n);
      q_rp_r  <= q_rp_r + QAW'(pop);
      q_cnt_r <= q_cnt_r + QCW'(push_n) - QCW'(pop);
      if (proc) begin
        if (ir_data_r.is_last) begin
          pos_r    <= '0;
          eth_hi_r <= '0;
          hc_r     <= '0;
          mtype_r  <= '0;
          xid_r    <= '0;
          hsh_r    <= '0;
          ph_r     <= PH_HDR;
          left_r   <= '0;
          cnt_r    <= '0;
          ids_r    <= '0;
          rv_r     <= VERDICT_OK;
        end else begin
          pos_r    <= pos_nxt;
          eth_hi_r <= eth_hi_nxt;
          hc_r     <= hc_nxt;
          mtype_r  <= mtype_nxt;
          xid_r    <= xid_nxt;
          hsh_r    <= hsh_nxt;
          ph_r     <= ph_nxt;
          left_r   <= left_nxt;
          cnt_r    <= cnt_nxt;
          ids_r    <= ids_nxt;
          rv_r     <= rv_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dopp_checker.sv -----
// Port checker for the DHCPv6 option parser, bound to the top level.
// Depends on dopp_pkg.
`default_nettype none

module dopp_checker
  import dopp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == KIND_VERDICT |->
      out_data.tlv_code == 16'd0 && out_data.option_length == 16'd0 &&
      out_data.data_offset == 16'd0 && out_data.end_of_run)
    else $error("verdict item carries option fields or lacks end mark");

  a_option_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == KIND_OPTION |->
      out_data.verdict == VERDICT_OK && out_data.options_found != '0)
    else $error("option item with verdict or zero count");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dhcpv6_packet_option_parser dopp_checker u_dopp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ----- sim/dhcpv6_packet_option_parser_tb.sv -----
// Testbench for dhcpv6_packet_option_parser: streams Ethernet frames byte by byte and checks
// every option and verdict item against an in-bench parser model.
// Depends on dopp_pkg and the parser top level in rtl.
`default_nettype none

module dhcpv6_packet_option_parser_tb
  import dopp_pkg::*;
();

  localparam int PH_HEADERS = 0;
  localparam int PH_HDR0    = 1;
  localparam int PH_HDR3    = 4;
  localparam int PH_DATA    = 5;
  localparam int PH_STOPPED = 6;

  typedef struct packed {
    bit [6:0]  hdr_len;
    bit        eth_ok;
    bit [7:0]  nh;
    bit [2:0]  n_opt;
    bit [15:0] code_a;
    bit [15:0] code_b;
    bit [15:0] len_a;
    bit [2:0]  cut;
    bit [2:0]  tail;
    bit [9:0]  max_opt;
    verdict_t  verdict;
  } frame_row_t;

  // hdr, eth ok, next header, options, code a, code b, length a, cut, tail, max_options, verdict
  localparam frame_row_t DIRECTED_FRAMES [21] = '{
    '{7'd1,  1'b1, 8'd17, 3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_NOT_IPV6},
    '{7'd13, 1'b1, 8'd17, 3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_NOT_IPV6},
    '{7'd14, 1'b0, 8'd17, 3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_NOT_IPV6},
    '{7'd14, 1'b1, 8'd17, 3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_TRUNCATED},
    '{7'd53, 1'b1, 8'd17, 3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_TRUNCATED},
    '{7'd54, 1'b1, 8'd6,  3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_NOT_UDP},
    '{7'd54, 1'b1, 8'd17, 3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_TRUNCATED},
    '{7'd65, 1'b1, 8'd17, 3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_TRUNCATED},
    '{7'd66, 1'b1, 8'd17, 3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_OK},
    '{7'd66, 1'b1, 8'd0,  3'd2, 16'h1, 16'h2, 16'd4, 3'd0, 3'd0, 10'd0, VERDICT_NOT_UDP},
    '{7'd66, 1'b0, 8'd17, 3'd2, 16'h1, 16'h1, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_NOT_IPV6},
    '{7'd66, 1'b1, 8'd17, 3'd2, 16'h1, 16'h2, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_OK},
    '{7'd66, 1'b1, 8'd17, 3'd3, 16'h1, 16'h1, 16'd0, 3'd0, 3'd0, 10'd0, VERDICT_DUP_CLIENT},
    '{7'd66, 1'b1, 8'd17, 3'd2, 16'h2, 16'h2, 16'd5, 3'd0, 3'd0, 10'd0, VERDICT_DUP_SERVER},
    '{7'd66, 1'b1, 8'd17, 3'd4, 16'h1, 16'h2, 16'd1, 3'd0, 3'd0, 10'd0, VERDICT_DUP_CLIENT},
    '{7'd66, 1'b1, 8'd17, 3'd3, 16'h1, 16'h1, 16'd3, 3'd1, 3'd0, 10'd0, VERDICT_MALFORMED},
    '{7'd66, 1'b1, 8'd17, 3'd1, 16'h5, 16'h0, 16'd6, 3'd2, 3'd0, 10'd0, VERDICT_MALFORMED},
    '{7'd66, 1'b1, 8'd17, 3'd1, 16'hFFFF, 16'h0, 16'd1, 3'd0, 3'd0, 10'd0, VERDICT_OK},
    '{7'd66, 1'b1, 8'd17, 3'd0, 16'h0, 16'h0, 16'd0, 3'd0, 3'd3, 10'd0, VERDICT_MALFORMED},
    '{7'd66, 1'b1, 8'd17, 3'd3, 16'h1, 16'h1, 16'd0, 3'd0, 3'd0, 10'd1, VERDICT_OK},
    '{7'd66, 1'b1, 8'd17, 3'd3, 16'h3, 16'h4, 16'd2, 3'd0, 3'd2, 10'd2, VERDICT_OK}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we;
  logic [MAX_OPTIONS_W-1:0] cfg_wdata;

  dhcpv6_packet_option_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // parser model state
  logic [MAX_OPTIONS_W-1:0] max_opts = MAX_OPTIONS_RESET;
  int unsigned frame_pos = 0;
  logic [7:0]  eth_hi = '0;
  logic [1:0]  hdr_faults = '0;
  logic [7:0]  msg_type_held = '0;
  logic [23:0] xid_held = '0;
  logic [31:0] opt_hdr = '0;
  int          opt_phase = PH_HEADERS;
  logic [15:0] data_left = '0;
  logic [MAX_OPTIONS_W-1:0] opt_count = '0;
  logic [1:0]  ids_seen = '0;
  verdict_t    dup_verdict = VERDICT_OK;

  out_item_t   expected_records [$];
  out_item_t   want;
  logic [7:0]  frame_q [$];
  int          errors = 0;
  int unsigned bytes_sent = 0;
  int          burst_left = 0;
  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;
  int unsigned ready_tick = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2400000;
    $display("** dhcpv6_packet_option_parser: FAILED **");
    $finish;
  end

  function automatic int boundary_phase();
    return (opt_count < max_opts) ? PH_HDR0 : PH_STOPPED;
  endfunction

  function automatic out_item_t take_option(int unsigned off);
    out_item_t r;
    opt_count = opt_count + 1'b1;
    if (opt_hdr[31:16] == OPT_CLIENT_ID) begin
      if (ids_seen[0] && dup_verdict == VERDICT_OK) dup_verdict = VERDICT_DUP_CLIENT;
      ids_seen[0] = 1'b1;
    end else if (opt_hdr[31:16] == OPT_SERVER_ID) begin
      if (ids_seen[1] && dup_verdict == VERDICT_OK) dup_verdict = VERDICT_DUP_SERVER;
      ids_seen[1] = 1'b1;
    end
    r.record_kind    = KIND_OPTION;
    r.tlv_code       = opt_hdr[31:16];
    r.option_length  = opt_hdr[15:0];
    r.data_offset    = off[15:0];
    r.verdict        = VERDICT_OK;
    r.message_type   = msg_type_held;
    r.transaction_id = xid_held;
    r.options_found  = opt_count;
    r.end_of_run     = 1'b0;
    opt_phase = boundary_phase();
    return r;
  endfunction

  function automatic verdict_t frame_verdict(int unsigned len);
    if (len < ETH_HDR_LEN || hdr_faults[0]) return VERDICT_NOT_IPV6;
    if (len < UDP_HDR_END) return VERDICT_TRUNCATED;
    if (hdr_faults[1]) return VERDICT_NOT_UDP;
    if (len < OPT_START) return VERDICT_TRUNCATED;
    if (opt_phase > PH_HDR0 && opt_phase <= PH_DATA) return VERDICT_MALFORMED;
    return dup_verdict;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last, input bit pinned,
                            input verdict_t pin_v);
    int unsigned p;
    int n;
    int k;
    out_item_t made [2];
    n = 0;
    p = frame_pos;
    if (p < DEFAULT_MAX_FRAME_BYTES) begin
      frame_pos = p + 1;
      if (p == POS_ETH_HI) begin
        eth_hi = b;
      end else if (p == POS_ETH_LO) begin
        if (eth_hi != ETH_TYPE_HI || b != ETH_TYPE_LO) hdr_faults[0] = 1'b1;
      end else if (p == POS_NEXT_HDR) begin
        if (b != NH_UDP) hdr_faults[1] = 1'b1;
      end else if (p == POS_MSG_TYPE) begin
        msg_type_held = b;
      end else if (p >= POS_XID_LO && p <= POS_XID_HI) begin
        xid_held = {xid_held[15:0], b};
        if (p == POS_XID_HI) opt_phase = boundary_phase();
      end else if (p >= OPT_START && hdr_faults == 2'b00) begin
        if (opt_phase >= PH_HDR0 && opt_phase <= PH_HDR3) begin
          opt_hdr = {opt_hdr[23:0], b};
          opt_phase++;
          if (opt_phase == PH_DATA) begin
            data_left = opt_hdr[15:0];
            if (data_left == 0) begin
              made[n] = take_option(p + 1);
              n++;
            end
          end
        end else if (opt_phase == PH_DATA) begin
          if (data_left > 0) data_left--;
          if (data_left == 0) begin
            made[n] = take_option(p - opt_hdr[15:0] + 1);
            n++;
          end
        end
      end
    end
    if (last) begin
      made[n] = '0;
      made[n].record_kind    = KIND_VERDICT;
      made[n].verdict        = pinned ? pin_v : frame_verdict(frame_pos);
      made[n].message_type   = msg_type_held;
      made[n].transaction_id = xid_held;
      made[n].options_found  = opt_count;
      n++;
      frame_pos = 0;
      eth_hi = '0;
      hdr_faults = '0;
      msg_type_held = '0;
      xid_held = '0;
      opt_hdr = '0;
      opt_phase = PH_HEADERS;
      data_left = '0;
      opt_count = '0;
      ids_seen = '0;
      dup_verdict = VERDICT_OK;
    end
    for (k = 0; k < n; k++) begin
      made[k].end_of_run = (k == n - 1);
      expected_records.push_back(made[k]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  task automatic set_max_options(input logic [MAX_OPTIONS_W-1:0] v);
    drain();
    repeat (8) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_opts = v;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit pinned,
                           input verdict_t pin_v);
    in_data <= '{frame_byte: b, is_last: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, last, pinned, pin_v);
    bytes_sent++;
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
    if ($urandom_range(0, 299) == 0) drain();
  endtask

  task automatic send_frame(input bit pinned, input verdict_t pin_v);
    int k;
    bit steady;
    steady = frame_q.size() > 1000;
    for (k = 0; k < frame_q.size(); k++) begin
      send_byte(frame_q[k], k == frame_q.size() - 1, pinned, pin_v);
      if (!steady) pace();
    end
  endtask

  task automatic put_header(input int n, input bit eth_ok, input logic [7:0] nh);
    logic [7:0] hi;
    logic [7:0] lo;
    int k;
    hi = ETH_TYPE_HI;
    lo = ETH_TYPE_LO;
    if (!eth_ok) begin
      do begin
        hi = $urandom_range(0, 1) ? ETH_TYPE_HI : 8'($urandom);
        lo = 8'($urandom);
      end while (hi == ETH_TYPE_HI && lo == ETH_TYPE_LO);
    end
    for (k = 0; k < n; k++) begin
      case (k)
        POS_ETH_HI:   frame_q.push_back(hi);
        POS_ETH_LO:   frame_q.push_back(lo);
        POS_NEXT_HDR: frame_q.push_back(nh);
        default:      frame_q.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic put_option(input logic [15:0] code, input logic [15:0] len);
    frame_q.push_back(code[15:8]);
    frame_q.push_back(code[7:0]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    repeat (len) frame_q.push_back(8'($urandom));
  endtask

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1, 2: return OPT_CLIENT_ID;
      3, 4:    return OPT_SERVER_ID;
      5:       return 16'h0000;
      6:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'd0;
      9:       return 16'($urandom_range(9, 48));
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic add_options(input int count);
    int k;
    for (k = 0; k < count; k++) put_option(pick_code(), pick_len());
  endtask

  task automatic build_random_frame();
    int sel;
    int room;
    logic [7:0] nh;
    frame_q.delete();
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      put_header(OPT_START, 1'b1, NH_UDP);
      add_options($urandom_range(0, 6));
      room = frame_q.size() - OPT_START;
      if (room > 0 && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, room < 6 ? room : 6)) void'(frame_q.pop_back());
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
    end else if (sel < 75) begin
      put_header(OPT_START, 1'b0, NH_UDP);
      add_options($urandom_range(0, 3));
    end else if (sel < 85) begin
      do nh = 8'($urandom); while (nh == NH_UDP);
      put_header(OPT_START, 1'b1, nh);
      add_options($urandom_range(0, 3));
    end else if (sel < 93) begin
      put_header($urandom_range(1, OPT_START - 1), 1'b1, NH_UDP);
    end else begin
      repeat ($urandom_range(1, 80)) frame_q.push_back(8'($urandom));
    end
  endtask

  function automatic logic [MAX_OPTIONS_W-1:0] pick_max();
    case ($urandom_range(0, 5))
      0:       return 10'd1;
      1:       return 10'd2;
      2:       return 10'd3;
      3:       return MAX_OPTIONS_RESET;
      default: return 10'($urandom_range(1, 512));
    endcase
  endfunction

  task automatic match_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
    end
  endtask

  // receiver: stall pattern switches at random among four modes
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(32, 400);
    end else begin
      ready_left--;
    end
    ready_tick++;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      2:       out_ready <= (ready_tick % 4 == 0);
      default: out_ready <= (ready_tick % 24 >= 16);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        errors++;
        $display("%0t: item %h arrived with none expected", $time, out_data);
      end else begin
        want = expected_records.pop_front();
        match_field("record_kind", want.record_kind, out_data.record_kind);
        match_field("tlv_code", want.tlv_code, out_data.tlv_code);
        match_field("option_length", want.option_length, out_data.option_length);
        match_field("data_offset", want.data_offset, out_data.data_offset);
        match_field("verdict", want.verdict, out_data.verdict);
        match_field("message_type", want.message_type, out_data.message_type);
        match_field("transaction_id", want.transaction_id, out_data.transaction_id);
        match_field("options_found", want.options_found, out_data.options_found);
        match_field("end_of_run", want.end_of_run, out_data.end_of_run);
      end
    end
  end

  initial begin
    int idx;
    int k;
    int frames;
    int unsigned random_from;
    int wait_cycles;
    frame_row_t row;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < 21; idx++) begin
      row = DIRECTED_FRAMES[idx];
      if (row.max_opt != 0) set_max_options(row.max_opt);
      frame_q.delete();
      put_header(row.hdr_len, row.eth_ok, row.nh);
      for (k = 0; k < row.n_opt; k++)
        put_option(k % 2 == 0 ? row.code_a : row.code_b, k % 2 == 0 ? row.len_a : 16'd0);
      repeat (row.cut) void'(frame_q.pop_back());
      repeat (row.tail) frame_q.push_back(8'($urandom));
      send_frame(1'b1, row.verdict);
    end

    frames = 0;
    random_from = bytes_sent;
    while (bytes_sent < random_from + 650) begin
      if (frames % 3 == 0) set_max_options(pick_max());
      build_random_frame();
      send_frame(1'b0, VERDICT_OK);
      frames++;
    end

    in_valid <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 20000 && expected_records.size() != 0; wait_cycles++)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (expected_records.size() != 0) begin
      errors += expected_records.size();
      $display("%0t: %0d items never arrived", $time, expected_records.size());
    end
    if (errors == 0) begin
      $display("** dhcpv6_packet_option_parser: PASSED **");
    end else begin
      $display("** dhcpv6_packet_option_parser: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/dopp_pkg.sv
rtl/dhcpv6_packet_option_parser.sv
rtl/dopp_checker.sv
sim/dhcpv6_packet_option_parser_tb.sv
